FILE: hdl/assert_macros.svh
// Assertion macros shared by the NPY header parser modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, switched off while reset is high.
`define NHP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, also while reset is high.
`define NHP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/nhp_pkg.sv
// Package of the NPY header parser: constants, codes, item and parser types.
// Depends on nothing; imported by every module of the parser.
package nhp_pkg;

   localparam int MAX_DIMS       = 4;
   localparam int MAX_HEADER_LEN = 65535;
   localparam int DIM_WIDTH      = 31;
   localparam int QUEUE_DEPTH    = 4;

   localparam int SC_W     = $clog2(MAX_DIMS + 1);
   localparam int DIM_IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DIM_WIDTH+3:0] DIM_LIMIT = {4'b0000, {DIM_WIDTH{1'b1}}};

   localparam logic [7:0] CH_QUOTE = 8'h27;

   localparam logic [0:4][7:0]  KEY_DESCR_S   = "descr";
   // The order key, spelled as its two words joined by an underscore.
   localparam logic [0:12][7:0] KEY_FORTRAN_S = {"fortran", "_", "order"};
   localparam logic [0:4][7:0]  KEY_SHAPE_S   = "shape";
   localparam logic [4:0] KEY_DESCR_LEN   = 5'd5;
   localparam logic [4:0] KEY_FORTRAN_LEN = 5'd13;
   localparam logic [4:0] KEY_SHAPE_LEN   = 5'd5;
   localparam logic [0:3][7:0]  WORD_TRUE_S  = "True";
   localparam logic [0:4][7:0]  WORD_FALSE_S = "False";

   localparam logic [1:0] KEY_DESCR   = 2'd0;
   localparam logic [1:0] KEY_FORTRAN = 2'd1;
   localparam logic [1:0] KEY_SHAPE   = 2'd2;

   localparam logic [2:0] DT_I1 = 3'd0;
   localparam logic [2:0] DT_I2 = 3'd1;
   localparam logic [2:0] DT_I4 = 3'd2;
   localparam logic [2:0] DT_U1 = 3'd3;
   localparam logic [2:0] DT_U2 = 3'd4;
   localparam logic [2:0] DT_F4 = 3'd5;
   localparam logic [2:0] DT_F8 = 3'd6;

   typedef enum logic [3:0] {
      ST_OK, ST_MAGIC, ST_TOO_LONG, ST_TOKEN, ST_GRAMMAR,
      ST_DTYPE, ST_KEY, ST_DIMS, ST_TRUNC, ST_OVERFLOW
   } status_type;

   typedef enum logic [3:0] {
      CL_SPACE, CL_LBR, CL_RBR, CL_LPA, CL_RPA, CL_COLON, CL_COMMA,
      CL_QUOTE, CL_T, CL_F, CL_DIGIT, CL_OTHER
   } class_type;

   typedef enum logic [3:0] {
      TK_LBR, TK_RBR, TK_LPA, TK_RPA, TK_COL, TK_COM, TK_STR, TK_TRUE, TK_FALSE, TK_INT
   } token_type;

   typedef enum logic [1:0] {PH_MAGIC, PH_LEN, PH_HDR, PH_DONE} phase_type;

   typedef enum logic [2:0] {LX_IDLE, LX_INT, LX_STR, LX_TRUE, LX_FALSE} lexer_type;

   typedef enum logic [3:0] {
      G_OPEN, G_KEY, G_COLON_D, G_COLON_F, G_COLON_S, G_DESCR, G_BOOL,
      G_LPAREN, G_ITEM, G_SEP, G_COMMA, G_CLOSED
   } grammar_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
      class_type  cls;
   } item_type;

   typedef struct packed {
      grammar_type                         gstate;
      logic [SC_W-1:0]                     shape_count;
      logic [MAX_DIMS-1:0][DIM_WIDTH-1:0]  dims;
      logic [2:0]                          type_code;
      logic                                order_flag;
   } parse_type;

   typedef struct packed {
      parse_type  p;
      status_type st;
   } feed_result_type;

   function automatic logic [7:0] magic_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0: b = 8'h93;
         3'd1: b = 8'h4E;
         3'd2: b = 8'h55;
         3'd3: b = 8'h4D;
         3'd4: b = 8'h50;
         3'd5: b = 8'h59;
         3'd6: b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

FILE: hdl/nhp_front.sv
// Front end of the NPY header parser: takes bytes and tags each with its class.
// Depends on nhp_pkg; feeds nhp_queue.
module nhp_front (
   input  logic              req_valid,
   input  logic [7:0]        req_data_byte,
   input  logic              req_file_start,
   input  logic              q_full,
   output logic              req_stall,
   output logic              push,
   output nhp_pkg::item_type push_item
);
   import nhp_pkg::*;

   function automatic class_type classify(input logic [7:0] c);
      class_type k;
      case (c)
         8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: k = CL_SPACE;
         8'h7B: k = CL_LBR;
         8'h7D: k = CL_RBR;
         8'h28: k = CL_LPA;
         8'h29: k = CL_RPA;
         8'h3A: k = CL_COLON;
         8'h2C: k = CL_COMMA;
         CH_QUOTE: k = CL_QUOTE;
         8'h54: k = CL_T;
         8'h46: k = CL_F;
         default: begin
            if (c >= 8'h30 && c <= 8'h39) k = CL_DIGIT;
            else k = CL_OTHER;
         end
      endcase
      return k;
   endfunction

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   always_comb begin
      push_item.data_byte  = req_data_byte;
      push_item.file_start = req_file_start;
      push_item.cls        = classify(req_data_byte);
   end

endmodule

FILE: hdl/nhp_queue.sv
// Short item queue between the front and back of the NPY header parser.
// Depends on nhp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module nhp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  nhp_pkg::item_type push_item,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output nhp_pkg::item_type head_item
);
   import nhp_pkg::*;

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = mem_ff[head_ff];

   always_comb begin
      head_in  = pop  ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[tail_ff] <= push_item;
      end
   end

   `NHP_ASSERT(a_count_range, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue count overran")
   `NHP_ASSERT(a_count_track, clock, reset, 1'b1 |=> count_ff == $past(count_ff) + QCNT_W'($past(push)) - QCNT_W'($past(pop)), "queue count lost an item")
   `NHP_ASSERT(a_empty_ptrs, clock, reset, count_ff == '0 |-> head_ff == tail_ff, "empty queue with apart pointers")

endmodule

FILE: hdl/nhp_back.sv
// Back end of the NPY header parser: magic, length, lexer, dict grammar, result.
// Depends on nhp_pkg and assert_macros.svh; takes items from nhp_queue.
`include "assert_macros.svh"
module nhp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  nhp_pkg::item_type item,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [3:0]        rsp_status,
   output logic [2:0]        rsp_element_type,
   output logic              rsp_column_major,
   output logic [2:0]        rsp_dim_count,
   output logic [30:0]       rsp_dim_zero,
   output logic [30:0]       rsp_dim_one,
   output logic [30:0]       rsp_dim_two,
   output logic [30:0]       rsp_dim_three,
   output logic [15:0]       rsp_header_bytes
);
   import nhp_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [15:0]          byte_count_ff, byte_count_in;
   logic [15:0]          header_length_ff, header_length_in;
   lexer_type            lexer_ff, lexer_in;
   parse_type            parse_ff, parse_in;
   logic [2:0]           key_bits_ff, key_bits_in;
   logic [4:0]           key_pos_ff, key_pos_in;
   logic [2:0][7:0]      type_chars_ff, type_chars_in;
   logic [2:0]           type_char_count_ff, type_char_count_in;
   logic [DIM_WIDTH-1:0] number_ff, number_in;
   logic [2:0]           kw_pos_ff, kw_pos_in;
   logic                 emit;
   status_type           emit_status;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [3:0]           status_ff;
   logic [2:0]           element_type_ff;
   logic                 column_major_ff;
   logic [2:0]           dim_count_ff, dim_count_in;
   logic [3:0][30:0]     dims_out_ff, dims_out_in;
   logic [15:0]          header_bytes_ff;

   function automatic feed_result_type feed(
      input parse_type            p,
      input token_type            t,
      input logic                 key_ok,
      input logic [1:0]           key,
      input logic                 dt_ok,
      input logic [2:0]           dt,
      input logic [DIM_WIDTH-1:0] num
   );
      feed_result_type r;
      r.p  = p;
      r.st = ST_OK;
      case (p.gstate)
         G_OPEN: begin
            if (t != TK_LBR) r.st = ST_GRAMMAR;
            else r.p.gstate = G_KEY;
         end
         G_KEY: begin
            if (t == TK_RBR) r.p.gstate = G_CLOSED;
            else if (t != TK_STR) r.st = ST_GRAMMAR;
            else if (!key_ok) r.st = ST_KEY;
            else if (key == KEY_DESCR) r.p.gstate = G_COLON_D;
            else if (key == KEY_FORTRAN) r.p.gstate = G_COLON_F;
            else r.p.gstate = G_COLON_S;
         end
         G_COLON_D, G_COLON_F, G_COLON_S: begin
            if (t != TK_COL) r.st = ST_GRAMMAR;
            else if (p.gstate == G_COLON_D) r.p.gstate = G_DESCR;
            else if (p.gstate == G_COLON_F) r.p.gstate = G_BOOL;
            else r.p.gstate = G_LPAREN;
         end
         G_DESCR: begin
            if (t != TK_STR) r.st = ST_GRAMMAR;
            else if (!dt_ok) r.st = ST_DTYPE;
            else begin
               r.p.type_code = dt;
               r.p.gstate    = G_COMMA;
            end
         end
         G_BOOL: begin
            if (t != TK_TRUE && t != TK_FALSE) r.st = ST_GRAMMAR;
            else begin
               r.p.order_flag = (t == TK_TRUE);
               r.p.gstate     = G_COMMA;
            end
         end
         G_LPAREN: begin
            if (t != TK_LPA) r.st = ST_GRAMMAR;
            else begin
               r.p.shape_count = '0;
               r.p.dims        = '0;
               r.p.gstate      = G_ITEM;
            end
         end
         G_ITEM: begin
            if (t == TK_RPA) r.p.gstate = G_COMMA;
            else if (t != TK_INT) r.st = ST_GRAMMAR;
            else if (p.shape_count >= SC_W'(MAX_DIMS)) r.st = ST_DIMS;
            else begin
               r.p.dims[p.shape_count[DIM_IDX_W-1:0]] = num;
               r.p.shape_count = p.shape_count + 1'b1;
               r.p.gstate      = G_SEP;
            end
         end
         G_SEP: begin
            if (t == TK_RPA) r.p.gstate = G_COMMA;
            else if (t != TK_COM) r.st = ST_GRAMMAR;
            else if (p.shape_count >= SC_W'(MAX_DIMS)) r.st = ST_DIMS;
            else r.p.gstate = G_ITEM;
         end
         G_COMMA: begin
            if (t != TK_COM) r.st = ST_GRAMMAR;
            else r.p.gstate = G_KEY;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [30:0] dim_at(
      input logic [MAX_DIMS-1:0][DIM_WIDTH-1:0] d,
      input int                                 i
   );
      logic [62:0] w;
      w = '0;
      for (int j = 0; j < MAX_DIMS; j++) begin
         if (j == i) w = 63'(d[j]);
      end
      return w[30:0];
   endfunction

   assign pop = q_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      phase_type            ph;
      logic [15:0]          bc, hl;
      lexer_type            lx;
      parse_type            ps;
      logic [2:0]           kb;
      logic [4:0]           kp;
      logic [2:0][7:0]      tc;
      logic [2:0]           tn, kw, kw_len;
      logic [DIM_WIDTH-1:0] num;
      logic [7:0]           c, want;
      status_type           st;
      feed_result_type      fr;
      logic                 key_ok, dt_ok, dispatch, tok_valid;
      logic [1:0]           key;
      logic [2:0]           dt;
      token_type            tok;
      logic [DIM_WIDTH+3:0] prod;
      logic [7:0]           cnt_wide;

      ph = phase_ff; bc = byte_count_ff; hl = header_length_ff; lx = lexer_ff;
      ps = parse_ff; kb = key_bits_ff; kp = key_pos_ff; tc = type_chars_ff;
      tn = type_char_count_ff; num = number_ff; kw = kw_pos_ff;
      if (item.file_start) begin
         ph = PH_MAGIC; bc = '0; hl = '0; lx = LX_IDLE;
         ps.gstate = G_OPEN; ps.shape_count = '0; ps.dims = '0;
         ps.type_code = '0; ps.order_flag = 1'b0;
         kb = 3'b111; kp = '0; tc = '0; tn = '0; num = '0; kw = '0;
      end
      c  = item.data_byte;
      st = ST_OK;
      emit = 1'b0;
      dispatch = 1'b0;
      tok_valid = 1'b0;
      tok = TK_LBR;
      want = 8'h00;
      kw_len = 3'd4;
      fr = '0;

      // The key and dtype seen so far, as the closing quote would report them.
      key_ok = 1'b1;
      if (kb[0] && kp == KEY_DESCR_LEN) key = KEY_DESCR;
      else if (kb[1] && kp == KEY_FORTRAN_LEN) key = KEY_FORTRAN;
      else if (kb[2] && kp == KEY_SHAPE_LEN) key = KEY_SHAPE;
      else begin
         key = KEY_DESCR;
         key_ok = 1'b0;
      end
      dt_ok = 1'b1;
      dt = DT_I1;
      if (tn != 3'd3 || tc[0] != 8'h3C) dt_ok = 1'b0;
      else begin
         case (tc[1])
            8'h69: begin
               if (tc[2] == 8'h31) dt = DT_I1;
               else if (tc[2] == 8'h32) dt = DT_I2;
               else if (tc[2] == 8'h34) dt = DT_I4;
               else dt_ok = 1'b0;
            end
            8'h75: begin
               if (tc[2] == 8'h31) dt = DT_U1;
               else if (tc[2] == 8'h32) dt = DT_U2;
               else dt_ok = 1'b0;
            end
            8'h66: begin
               if (tc[2] == 8'h34) dt = DT_F4;
               else if (tc[2] == 8'h38) dt = DT_F8;
               else dt_ok = 1'b0;
            end
            default: dt_ok = 1'b0;
         endcase
      end
      prod = {1'b0, num, 3'b000} + {3'b000, num, 1'b0} + (DIM_WIDTH+4)'(c[3:0]);

      case (ph)
         PH_MAGIC: begin
            if (c != magic_byte(bc[2:0])) begin
               emit = 1'b1;
               st = ST_MAGIC;
            end else begin
               bc = bc + 16'd1;
               if (bc >= 16'd8) ph = PH_LEN;
            end
         end
         PH_LEN: begin
            if (bc == 16'd8) begin
               hl = {8'h00, c};
               bc = 16'd9;
            end else begin
               hl = {c, hl[7:0]};
               if (17'(hl) > 17'(MAX_HEADER_LEN)) begin
                  emit = 1'b1;
                  st = ST_TOO_LONG;
               end else if (hl == 16'd0) begin
                  emit = 1'b1;
                  st = ST_TRUNC;
               end else begin
                  ph = PH_HDR;
                  bc = '0;
               end
            end
         end
         PH_HDR: begin
            if (ps.gstate != G_CLOSED) begin
               case (lx)
                  LX_STR: begin
                     if (c == CH_QUOTE) begin
                        lx = LX_IDLE;
                        fr = feed(ps, TK_STR, key_ok, key, dt_ok, dt, num);
                        ps = fr.p;
                        st = fr.st;
                     end else if (c == 8'h00) begin
                        st = ST_TOKEN;
                     end else begin
                        if (kp >= KEY_DESCR_LEN || KEY_DESCR_S[kp[2:0]] != c) kb[0] = 1'b0;
                        if (kp >= KEY_FORTRAN_LEN || KEY_FORTRAN_S[kp[3:0]] != c)
                           kb[1] = 1'b0;
                        if (kp >= KEY_SHAPE_LEN || KEY_SHAPE_S[kp[2:0]] != c) kb[2] = 1'b0;
                        if (kp < 5'd31) kp = kp + 5'd1;
                        if (tn < 3'd3) tc[tn[1:0]] = c;
                        if (tn < 3'd7) tn = tn + 3'd1;
                     end
                  end
                  LX_INT: begin
                     if (item.cls == CL_DIGIT) begin
                        if (prod > DIM_LIMIT) st = ST_OVERFLOW;
                        else num = prod[DIM_WIDTH-1:0];
                     end else begin
                        lx = LX_IDLE;
                        fr = feed(ps, TK_INT, key_ok, key, dt_ok, dt, num);
                        ps = fr.p;
                        st = fr.st;
                        dispatch = (fr.st == ST_OK);
                     end
                  end
                  LX_TRUE, LX_FALSE: begin
                     if (lx == LX_TRUE) begin
                        want = WORD_TRUE_S[kw[1:0]];
                        kw_len = 3'd4;
                     end else begin
                        want = (kw < 3'd5) ? WORD_FALSE_S[kw] : WORD_FALSE_S[0];
                        kw_len = 3'd5;
                     end
                     if (c != want) st = ST_TOKEN;
                     else begin
                        kw = kw + 3'd1;
                        if (kw >= kw_len) begin
                           fr = feed(ps, (lx == LX_TRUE) ? TK_TRUE : TK_FALSE,
                                     key_ok, key, dt_ok, dt, num);
                           lx = LX_IDLE;
                           ps = fr.p;
                           st = fr.st;
                        end
                     end
                  end
                  default: dispatch = 1'b1;
               endcase

               // Byte seen between tokens, possibly right after an integer ended.
               if (dispatch) begin
                  case (item.cls)
                     CL_SPACE: ;
                     CL_LBR: begin tok_valid = 1'b1; tok = TK_LBR; end
                     CL_RBR: begin tok_valid = 1'b1; tok = TK_RBR; end
                     CL_LPA: begin tok_valid = 1'b1; tok = TK_LPA; end
                     CL_RPA: begin tok_valid = 1'b1; tok = TK_RPA; end
                     CL_COLON: begin tok_valid = 1'b1; tok = TK_COL; end
                     CL_COMMA: begin tok_valid = 1'b1; tok = TK_COM; end
                     CL_QUOTE: begin
                        lx = LX_STR; kb = 3'b111; kp = '0; tn = '0; tc = '0;
                     end
                     CL_T: begin lx = LX_TRUE; kw = 3'd1; end
                     CL_F: begin lx = LX_FALSE; kw = 3'd1; end
                     CL_DIGIT: begin
                        lx = LX_INT;
                        num = DIM_WIDTH'(c[3:0]);
                     end
                     default: st = ST_TOKEN;
                  endcase
                  if (tok_valid) begin
                     fr = feed(ps, tok, key_ok, key, dt_ok, dt, num);
                     ps = fr.p;
                     st = fr.st;
                  end
               end
            end
            bc = bc + 16'd1;
            if (st != ST_OK) begin
               emit = 1'b1;
            end else if (bc == hl) begin
               // Header end: hand over a pending integer, then check closure.
               emit = 1'b1;
               if (lx == LX_INT) begin
                  lx = LX_IDLE;
                  fr = feed(ps, TK_INT, key_ok, key, dt_ok, dt, num);
                  ps = fr.p;
                  st = fr.st;
               end
               if (st == ST_OK) begin
                  if (lx == LX_STR) st = ST_TRUNC;
                  else if (lx == LX_TRUE || lx == LX_FALSE) st = ST_TOKEN;
                  else if (ps.gstate != G_CLOSED) st = ST_TRUNC;
               end
            end
         end
         default: ;
      endcase
      if (emit) ph = PH_DONE;

      phase_in = ph; byte_count_in = bc; header_length_in = hl; lexer_in = lx;
      parse_in = ps; key_bits_in = kb; key_pos_in = kp; type_chars_in = tc;
      type_char_count_in = tn; number_in = num; kw_pos_in = kw;
      emit_status = st;
      cnt_wide = 8'(ps.shape_count);
      for (int i = 0; i < 4; i++) begin
         dims_out_in[i] = dim_at(ps.dims, i);
      end
      rsp_valid_in = (pop && emit) ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      if (pop && emit) begin
         dim_count_in = cnt_wide[2:0];
      end else begin
         dim_count_in = dim_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_MAGIC;
         byte_count_ff      <= '0;
         header_length_ff   <= '0;
         lexer_ff           <= LX_IDLE;
         parse_ff           <= '{gstate: G_OPEN, shape_count: '0, dims: '0,
                                 type_code: '0, order_flag: 1'b0};
         key_bits_ff        <= 3'b111;
         key_pos_ff         <= '0;
         type_chars_ff      <= '0;
         type_char_count_ff <= '0;
         number_ff          <= '0;
         kw_pos_ff          <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff           <= phase_in;
            byte_count_ff      <= byte_count_in;
            header_length_ff   <= header_length_in;
            lexer_ff           <= lexer_in;
            parse_ff           <= parse_in;
            key_bits_ff        <= key_bits_in;
            key_pos_ff         <= key_pos_in;
            type_chars_ff      <= type_chars_in;
            type_char_count_ff <= type_char_count_in;
            number_ff          <= number_in;
            kw_pos_ff          <= kw_pos_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         status_ff       <= emit_status;
         element_type_ff <= parse_in.type_code;
         column_major_ff <= parse_in.order_flag;
         dims_out_ff     <= dims_out_in;
         header_bytes_ff <= header_length_in;
      end
      dim_count_ff <= dim_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_element_type = element_type_ff;
   assign rsp_column_major = column_major_ff;
   assign rsp_dim_count    = dim_count_ff;
   assign rsp_dim_zero     = dims_out_ff[0];
   assign rsp_dim_one      = dims_out_ff[1];
   assign rsp_dim_two      = dims_out_ff[2];
   assign rsp_dim_three    = dims_out_ff[3];
   assign rsp_header_bytes = header_bytes_ff;

   `NHP_ASSERT(a_emit_done, clock, reset, pop && emit |=> phase_ff == PH_DONE && rsp_valid_ff, "result given without closing the file")
   `NHP_ASSERT(a_rsp_hold, clock, reset, rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(status_ff), "stalled result changed")
   `NHP_ASSERT(a_no_pop_blocked, clock, reset, rsp_valid_ff && rsp_stall |-> !pop, "item taken while a result waits")

endmodule

FILE: hdl/npy_header_parser.sv
// Top level of the NPY header parser: front classifier, item queue, back parser.
// Depends on nhp_pkg, nhp_front, nhp_queue and nhp_back.
//
//   Channel   Direction   Handshake                Payload
//   req_      in          req_valid / req_stall    req_data_byte, req_file_start
//   rsp_      out         rsp_valid / rsp_stall    status, element_type, column_major,
//                                                  dim_count, dim_*, header_bytes
//
// The parser sustains one byte item per clock while no result waits under rsp_stall.
// The front tags a byte with its class and writes it into a four-entry queue; the
// back takes one item a cycle from the queue, and a result is registered in the back
// once its byte leaves the queue. The back stops only while a result waits under
// rsp_stall, and the front stalls the requester only when the queue is full.
// Reset is synchronous and active high; it empties the queue and returns the
// parser to the magic phase with every parsed field cleared.
module npy_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_file_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [2:0]  rsp_element_type,
   output logic        rsp_column_major,
   output logic [2:0]  rsp_dim_count,
   output logic [30:0] rsp_dim_zero,
   output logic [30:0] rsp_dim_one,
   output logic [30:0] rsp_dim_two,
   output logic [30:0] rsp_dim_three,
   output logic [15:0] rsp_header_bytes
);
   import nhp_pkg::*;

   // Items travel front -> queue -> back; the queue decouples the two stall sides.
   logic     push, pop, q_full, q_valid;
   item_type push_item, head_item;

   nhp_front u_front (
      .req_valid      (req_valid),
      .req_data_byte  (req_data_byte),
      .req_file_start (req_file_start),
      .q_full         (q_full),
      .req_stall      (req_stall),
      .push           (push),
      .push_item      (push_item)
   );

   nhp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head_item (head_item)
   );

   // The back holds the whole parser state and the result register.
   nhp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .item             (head_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_element_type (rsp_element_type),
      .rsp_column_major (rsp_column_major),
      .rsp_dim_count    (rsp_dim_count),
      .rsp_dim_zero     (rsp_dim_zero),
      .rsp_dim_one      (rsp_dim_one),
      .rsp_dim_two      (rsp_dim_two),
      .rsp_dim_three    (rsp_dim_three),
      .rsp_header_bytes (rsp_header_bytes)
   );

endmodule

FILE: bench/npy_header_checker.sv
// Checker for the NPY header parser: watches both channels, predicts each result.
// Depends on nhp_pkg; instantiated beside the parser by tb_npy_header_parser.
module npy_header_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_file_start,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_status,
   input  logic [2:0]  rsp_element_type,
   input  logic        rsp_column_major,
   input  logic [2:0]  rsp_dim_count,
   input  logic [30:0] rsp_dim_zero,
   input  logic [30:0] rsp_dim_one,
   input  logic [30:0] rsp_dim_two,
   input  logic [30:0] rsp_dim_three,
   input  logic [15:0] rsp_header_bytes,
   output int          fail_count,
   output int          results_owed
);
   import nhp_pkg::*;

   localparam longint DIM_MAX = (64'd1 << DIM_WIDTH) - 1;

   typedef struct packed {
      logic [3:0]        status;
      logic [2:0]        element_type;
      logic              column_major;
      logic [2:0]        dim_count;
      logic [3:0][30:0]  dims;
      logic [15:0]       header_bytes;
   } header_summary_type;

   header_summary_type summaries_due[$];

   logic [7:0]  magic_seq [8] = '{8'h93, "N", "U", "M", "P", "Y", 8'h01, 8'h00};

   phase_type   ph;
   lexer_type   lx;
   grammar_type gs;
   logic [15:0] nbytes, hdr_len;
   logic [2:0]  key_mask;
   int          key_pos, kw_pos, tchar_cnt, dim_cnt;
   logic [7:0]  tchars [3];
   longint      accum;
   logic [3:0][30:0] dims;
   logic [2:0]  dtype_code;
   logic        fortran;

   function automatic void clear_parser();
      ph = PH_MAGIC; lx = LX_IDLE; gs = G_OPEN;
      nbytes = 0; hdr_len = 0; key_mask = 3'b111; key_pos = 0; kw_pos = 0;
      tchar_cnt = 0; dim_cnt = 0; accum = 0; dims = '0; dtype_code = 0; fortran = 0;
      tchars = '{8'h00, 8'h00, 8'h00};
   endfunction

   function automatic int key_length(int k);
      return (k == KEY_FORTRAN) ? KEY_FORTRAN_LEN : KEY_DESCR_LEN;
   endfunction

   function automatic logic [7:0] key_char(int k, int p);
      case (k)
         KEY_DESCR:   return KEY_DESCR_S[p];
         KEY_FORTRAN: return KEY_FORTRAN_S[p];
         default:     return KEY_SHAPE_S[p];
      endcase
   endfunction

   // A dtype string must be exactly three characters, little endian first.
   function automatic int dtype_of_string();
      if (tchar_cnt != 3 || tchars[0] != "<") return 8;
      case (tchars[1])
         "i": case (tchars[2]) "1": return DT_I1; "2": return DT_I2; "4": return DT_I4;
              default: return 8; endcase
         "u": case (tchars[2]) "1": return DT_U1; "2": return DT_U2; default: return 8; endcase
         "f": case (tchars[2]) "4": return DT_F4; "8": return DT_F8; default: return 8; endcase
         default: return 8;
      endcase
   endfunction

   function automatic status_type grammar_token(token_type t);
      int k, d;
      case (gs)
         G_OPEN: begin
            if (t != TK_LBR) return ST_GRAMMAR;
            gs = G_KEY;
         end
         G_KEY: begin
            if (t == TK_RBR) begin
               gs = G_CLOSED;
               return ST_OK;
            end
            if (t != TK_STR) return ST_GRAMMAR;
            k = -1;
            for (int i = 2; i >= 0; i--)
               if (key_mask[i] && key_pos == key_length(i)) k = i;
            if (k < 0) return ST_KEY;
            gs = (k == KEY_DESCR) ? G_COLON_D : (k == KEY_FORTRAN) ? G_COLON_F : G_COLON_S;
         end
         G_COLON_D, G_COLON_F, G_COLON_S: begin
            if (t != TK_COL) return ST_GRAMMAR;
            gs = (gs == G_COLON_D) ? G_DESCR : (gs == G_COLON_F) ? G_BOOL : G_LPAREN;
         end
         G_DESCR: begin
            if (t != TK_STR) return ST_GRAMMAR;
            d = dtype_of_string();
            if (d > 6) return ST_DTYPE;
            dtype_code = 3'(d);
            gs = G_COMMA;
         end
         G_BOOL: begin
            if (t != TK_TRUE && t != TK_FALSE) return ST_GRAMMAR;
            fortran = (t == TK_TRUE);
            gs = G_COMMA;
         end
         G_LPAREN: begin
            if (t != TK_LPA) return ST_GRAMMAR;
            dim_cnt = 0;
            dims = '0;
            gs = G_ITEM;
         end
         G_ITEM: begin
            if (t == TK_RPA) begin
               gs = G_COMMA;
               return ST_OK;
            end
            if (t != TK_INT) return ST_GRAMMAR;
            if (dim_cnt >= MAX_DIMS) return ST_DIMS;
            dims[dim_cnt] = accum[30:0];
            dim_cnt++;
            gs = G_SEP;
         end
         G_SEP: begin
            if (t == TK_RPA) begin
               gs = G_COMMA;
               return ST_OK;
            end
            if (t != TK_COM) return ST_GRAMMAR;
            if (dim_cnt >= MAX_DIMS) return ST_DIMS;
            gs = G_ITEM;
         end
         G_COMMA: begin
            if (t != TK_COM) return ST_GRAMMAR;
            gs = G_KEY;
         end
         default: ;
      endcase
      return ST_OK;
   endfunction

   function automatic status_type lex_byte(logic [7:0] c);
      status_type st;
      logic [7:0] want;
      longint dig;
      dig = longint'(c) - 48;
      if (lx == LX_STR) begin
         if (c == CH_QUOTE) begin
            lx = LX_IDLE;
            return grammar_token(TK_STR);
         end
         if (c == 8'h00) return ST_TOKEN;
         for (int k = 0; k < 3; k++)
            if (key_pos >= key_length(k) || key_char(k, key_pos) != c) key_mask[k] = 1'b0;
         if (key_pos < 31) key_pos++;
         if (tchar_cnt < 3) tchars[tchar_cnt] = c;
         if (tchar_cnt < 7) tchar_cnt++;
         return ST_OK;
      end
      if (lx == LX_INT) begin
         if (c >= "0" && c <= "9") begin
            if (accum > (DIM_MAX - dig) / 10) return ST_OVERFLOW;
            accum = accum * 10 + dig;
            return ST_OK;
         end
         // A non-digit ends the integer, then is lexed on its own.
         lx = LX_IDLE;
         st = grammar_token(TK_INT);
         if (st != ST_OK) return st;
      end
      if (lx == LX_TRUE || lx == LX_FALSE) begin
         want = (lx == LX_TRUE) ? WORD_TRUE_S[kw_pos & 3] : WORD_FALSE_S[kw_pos];
         if (c != want) return ST_TOKEN;
         kw_pos++;
         if (kw_pos >= ((lx == LX_TRUE) ? 4 : 5)) begin
            st = grammar_token((lx == LX_TRUE) ? TK_TRUE : TK_FALSE);
            lx = LX_IDLE;
            return st;
         end
         return ST_OK;
      end
      case (c)
         8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: return ST_OK;
         "{": return grammar_token(TK_LBR);
         "}": return grammar_token(TK_RBR);
         "(": return grammar_token(TK_LPA);
         ")": return grammar_token(TK_RPA);
         ":": return grammar_token(TK_COL);
         ",": return grammar_token(TK_COM);
         CH_QUOTE: begin
            lx = LX_STR; key_mask = 3'b111; key_pos = 0; tchar_cnt = 0;
            tchars = '{8'h00, 8'h00, 8'h00};
            return ST_OK;
         end
         "T": begin
            lx = LX_TRUE; kw_pos = 1;
            return ST_OK;
         end
         "F": begin
            lx = LX_FALSE; kw_pos = 1;
            return ST_OK;
         end
         default: begin
            if (c >= "0" && c <= "9") begin
               lx = LX_INT; accum = dig;
               return ST_OK;
            end
            return ST_TOKEN;
         end
      endcase
   endfunction

   function automatic status_type header_end_status();
      status_type st;
      if (lx == LX_INT) begin
         lx = LX_IDLE;
         st = grammar_token(TK_INT);
         if (st != ST_OK) return st;
      end
      if (lx == LX_STR) return ST_TRUNC;
      if (lx == LX_TRUE || lx == LX_FALSE) return ST_TOKEN;
      return (gs == G_CLOSED) ? ST_OK : ST_TRUNC;
   endfunction

   function automatic void post_summary(status_type st);
      header_summary_type s;
      ph = PH_DONE;
      s.status = st; s.element_type = dtype_code; s.column_major = fortran;
      s.dim_count = dim_cnt[2:0]; s.dims = dims; s.header_bytes = hdr_len;
      summaries_due.push_back(s);
   endfunction

   function automatic void take_byte(logic [7:0] c, logic fs);
      status_type st;
      if (fs) clear_parser();
      case (ph)
         PH_MAGIC: begin
            if (c != magic_seq[nbytes[2:0]]) begin
               post_summary(ST_MAGIC);
               return;
            end
            nbytes++;
            if (nbytes >= 8) ph = PH_LEN;
         end
         PH_LEN: begin
            if (nbytes == 8) begin
               hdr_len = {8'h00, c};
               nbytes = 9;
               return;
            end
            hdr_len[15:8] = c;
            if (hdr_len == 0) begin
               post_summary(ST_TRUNC);
               return;
            end
            ph = PH_HDR;
            nbytes = 0;
         end
         PH_HDR: begin
            st = ST_OK;
            if (gs != G_CLOSED) st = lex_byte(c);
            nbytes++;
            if (st != ST_OK) post_summary(st);
            else if (nbytes == hdr_len) post_summary(header_end_status());
         end
         default: ;
      endcase
   endfunction

   assign results_owed = summaries_due.size();

   always @(posedge clock) begin
      header_summary_type want, got;
      if (reset) begin
         clear_parser();
         summaries_due.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.status = rsp_status; got.element_type = rsp_element_type;
            got.column_major = rsp_column_major; got.dim_count = rsp_dim_count;
            got.dims = {rsp_dim_three, rsp_dim_two, rsp_dim_one, rsp_dim_zero};
            got.header_bytes = rsp_header_bytes;
            if (summaries_due.size() == 0) begin
               if (fail_count < 10) $display("unexpected result: status %0d", got.status);
               fail_count <= fail_count + 1;
            end else begin
               want = summaries_due.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) begin
                     $display("mismatch: want st %0d ty %0d cm %0d n %0d d %0d %0d %0d %0d hb %0d",
                        want.status, want.element_type, want.column_major, want.dim_count,
                        want.dims[0], want.dims[1], want.dims[2], want.dims[3],
                        want.header_bytes);
                     $display("          got  st %0d ty %0d cm %0d n %0d d %0d %0d %0d %0d hb %0d",
                        got.status, got.element_type, got.column_major, got.dim_count,
                        got.dims[0], got.dims[1], got.dims[2], got.dims[3],
                        got.header_bytes);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) take_byte(req_data_byte, req_file_start);
      end
   end

endmodule

FILE: bench/tb_npy_header_parser.sv
// Testbench top for the NPY header parser: builds NPY file prefixes and streams them.
// Depends on nhp_pkg, npy_header_parser and npy_header_checker.
module tb_npy_header_parser;
   import nhp_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_file_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_status;
   logic [2:0]  rsp_element_type;
   logic        rsp_column_major;
   logic [2:0]  rsp_dim_count;
   logic [30:0] rsp_dim_zero, rsp_dim_one, rsp_dim_two, rsp_dim_three;
   logic [15:0] rsp_header_bytes;

   int          fail_count, results_owed;
   int          cycle_count = 0;
   int          bytes_sent = 0;
   int          stall_left = 0;
   // While calm is set neither side idles, so back-to-back items get exercised.
   bit          calm = 1'b0;
   // The memory order key as it appears in a header.
   string       order_key = {"fortran", "_", "order"};

   always #2 clock = ~clock;

   npy_header_parser u_dut (.*);
   npy_header_checker u_checker (.*);

   // The run is bounded well above the slowest legal run of the stimulus below.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // After each result it takes, the result side may hold stall for a random stretch.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (rsp_valid && !rsp_stall) stall_left <= calm ? 0 : $urandom_range(0, 11);
      end
   end

   // Presents one byte item after a random gap and waits until it is taken.
   task automatic send_byte(logic [7:0] b, logic fs);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_file_start <= fs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   // Sends the magic, the little-endian header length and then the header text.
   // A cut below the full size models a prefix that stops early.
   task automatic send_file(string hdr, int hlen, int cut = -1);
      logic [7:0] bytes_q [$];
      bytes_q = '{8'h93, "N", "U", "M", "P", "Y", 8'h01, 8'h00, hlen[7:0], hlen[15:8]};
      for (int i = 0; i < hdr.len(); i++) bytes_q.push_back(hdr[i]);
      if (cut >= 0 && cut < bytes_q.size()) bytes_q = bytes_q[0:cut];
      foreach (bytes_q[i]) send_byte(bytes_q[i], i == 0);
   endtask

   function automatic string blanks();
      string s, pool;
      pool = " \t\n\r\v\f";
      s = "";
      repeat ($urandom_range(0, 2)) s = {s, string'(pool[$urandom_range(0, 5)])};
      return s;
   endfunction

   function automatic string dim_text();
      case ($urandom_range(0, 9))
         0:       return "2147483647";
         1:       return "2147483648";
         2:       return $sformatf("%0d", $urandom_range(0, 32'h7FFFFFFF));
         3:       return "0";
         default: return $sformatf("%0d", $urandom_range(0, 999));
      endcase
   endfunction

   // A mostly well-formed header dict with random keys, values, order and spacing.
   function automatic string random_dict();
      string types [10] = '{"<i1", "<i2", "<i4", "<u1", "<u2", "<f4", "<f8",
                            "<i8", ">f4", "<f44"};
      string parts [$], hdr, shp;
      int n;
      if ($urandom_range(0, 3) != 0)
         parts.push_back({"'descr'", blanks(), ":", blanks(), "'",
                          types[$urandom_range(0, 9)], "'"});
      if ($urandom_range(0, 3) != 0)
         parts.push_back({"'", order_key, "':", blanks(),
                          $urandom_range(0, 1) ? string'("True") : string'("False")});
      if ($urandom_range(0, 3) != 0) begin
         n = $urandom_range(0, 5);
         shp = "(";
         for (int i = 0; i < n; i++)
            shp = {shp, (i > 0) ? string'(",") : string'(""), blanks(), dim_text()};
         if (n > 0 && $urandom_range(0, 2) == 0) shp = {shp, ","};
         parts.push_back({"'shape':", blanks(), shp, blanks(), ")"});
      end
      if ($urandom_range(0, 9) == 0) parts.push_back("'shapes': (1,)");
      parts.shuffle();
      hdr = {"{", blanks()};
      foreach (parts[i]) hdr = {hdr, parts[i], ",", blanks()};
      hdr = {hdr, "}"};
      repeat ($urandom_range(0, 6)) hdr = {hdr, " "};
      return {hdr, "\n"};
   endfunction

   initial begin
      string hdr;
      int    hlen, pick, files;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed files: extremes, each dtype, and every special case by name.
      send_file("{}\n", 3);
      send_file({"{'descr': '<f8', '", order_key,
                 "': True, 'shape': (2147483647, 0, 7, 1), }"}, 72);
      send_file("{'descr':'<i1','descr':'<i2','shape':(3,4),'shape':(5,),}", 58);
      send_file({"{'descr':'<i4','", order_key, "':False,}"}, 38);
      send_file("{'descr':'<u1',}", 16);
      send_file("{'descr':'<u2',}", 16);
      send_file("{'descr':'<f4',}", 16);
      send_file("{'descr':'<c8',}", 16);
      send_file("{'shape':(2147483648,),}", 24);
      send_file("{'shape':(1,2,3,4,),}", 21);
      send_file("{'shape':(1,2,3,4,5),}", 22);
      send_file("{'shape':(12", 12);
      send_file("{'descr':'<i", 12);
      send_file({"{'", order_key, "':Tru"}, 20);
      send_file({"{'", order_key, "':Flase,}"}, 24);
      send_file("{'descr':'a\000',}", 16);
      send_file("{'bogus':1,}", 12);
      send_file("{}  trailing junk ignored", 25);
      send_file("{", 0);
      send_file("{}", 2, 5);
      send_file("x", 1);
      send_byte("Q", 1'b1);
      send_file("{'shape':()", 11);

      // Random files until enough bytes have gone through.
      files = 0;
      while (bytes_sent < 1600) begin
         if (files % 15 == 0) calm = ($urandom_range(0, 3) == 0);
         hdr = random_dict();
         hlen = hdr.len();
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            repeat ($urandom_range(1, 3)) hdr.putc($urandom_range(0, hdr.len() - 1),
                                                    8'($urandom_range(0, 255)));
         end else if (pick < 22) begin
            hlen = $urandom_range(0, hlen - 1);
         end else if (pick < 27) begin
            hlen = hlen + $urandom_range(1, 4);
            repeat (hlen - hdr.len()) hdr = {hdr, string'(8'($urandom_range(0, 255)))};
         end
         if (pick >= 95 && pick < 98) begin
            send_file(hdr, hlen, $urandom_range(0, 15));
         end else if (pick >= 98) begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
            repeat ($urandom_range(0, 20)) send_byte(8'($urandom_range(0, 255)), 1'b0);
         end else begin
            send_file(hdr, hlen);
         end
         files++;
      end
      req_valid <= 1'b0;

      while (results_owed != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/nhp_pkg.sv
hdl/nhp_front.sv
hdl/nhp_queue.sv
hdl/nhp_back.sv
hdl/npy_header_parser.sv
bench/npy_header_checker.sv
bench/tb_npy_header_parser.sv
